@@ sv/assert_macros.svh @@
// Assertion macros shared by the line-of-sight checker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock, off while reset is held.
`define GLOS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle requires the consequent in the next.
`define GLOS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/glos_pkg.sv @@
// Types and constants of the grid line-of-sight checker.
package glos_pkg;

    localparam int COORD_W = 9;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    typedef struct packed {
        logic               operation;
        logic [COORD_W-1:0] point_a_x;
        logic [COORD_W-1:0] point_a_y;
        logic [COORD_W-1:0] point_b_x;
        logic [COORD_W-1:0] point_b_y;
        logic               cell_blocked;
    } cmd_t;

    typedef struct packed {
        logic               line_clear;
        logic [COORD_W-1:0] cells_visited;
    } result_t;

    // Walk setup handed to the stepper
    typedef struct packed {
        logic                      y_major;
        logic [COORD_W-1:0]        major_start;
        logic [COORD_W-1:0]        minor_start;
        logic [COORD_W-1:0]        major_delta;
        logic signed [COORD_W:0]   minor_delta;
    } step_cfg_t;

    typedef struct packed {
        logic at_start;
        logic at_end;
    } step_stat_t;

endpackage

@@ sv/glos_ram.sv @@
// Generic simple dual-port RAM with registered read.
module glos_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ sv/glos_stepper.sv @@
// Exact rational line stepper: one cell position per advance.
module glos_stepper (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     load,
    input  glos_pkg::step_cfg_t      cfg,
    input  logic                     advance,
    output logic [glos_pkg::COORD_W-1:0] cell_x,
    output logic [glos_pkg::COORD_W-1:0] cell_y,
    output glos_pkg::step_stat_t     stat
);

    import glos_pkg::*;

    localparam int REM_W = COORD_W + 2;

    step_cfg_t                cfg_reg;
    logic [COORD_W-1:0]       step_reg;
    logic [COORD_W-1:0]       major_reg;
    logic [COORD_W-1:0]       minor_reg;
    logic signed [REM_W-1:0]  rem_reg;

    logic signed [REM_W-1:0]  delta_ext;
    logic signed [REM_W-1:0]  rem_sum;
    logic signed [REM_W-1:0]  rem_next;
    logic [COORD_W-1:0]       minor_next;

    // rem tracks i*minor_delta mod major_delta, kept in [0, major_delta)
    always_comb
    begin
        delta_ext = $signed({2'b00, cfg_reg.major_delta});
        rem_sum   = rem_reg + REM_W'(cfg_reg.minor_delta);
        priority if (rem_sum >= delta_ext)
        begin
            rem_next   = rem_sum - delta_ext;
            minor_next = minor_reg + 1'b1;
        end
        else if (rem_sum < 0)
        begin
            rem_next   = rem_sum + delta_ext;
            minor_next = minor_reg - 1'b1;
        end
        else
        begin
            rem_next   = rem_sum;
            minor_next = minor_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (load)
        begin
            step_reg <= '0;
        end
        else if (advance)
        begin
            step_reg <= step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cfg_reg   <= cfg;
            major_reg <= cfg.major_start;
            minor_reg <= cfg.minor_start;
            rem_reg   <= '0;
        end
        else if (advance)
        begin
            major_reg <= major_reg + 1'b1;
            minor_reg <= minor_next;
            rem_reg   <= rem_next;
        end
    end

    assign cell_x        = cfg_reg.y_major ? minor_reg : major_reg;
    assign cell_y        = cfg_reg.y_major ? major_reg : minor_reg;
    assign stat.at_start = (step_reg == '0);
    assign stat.at_end   = (step_reg == cfg_reg.major_delta);

endmodule

@@ sv/grid_line_of_sight_check.sv @@
// Top level of the grid line-of-sight checker.
//
//  channel | dir | handshake               | payload
//  cmd     | in  | start & !busy           | cmd (write cell or check line)
//  result  | out | done, one cycle         | result (line_clear, cells_visited)
//
// A write is stored when it is taken and leaves busy low.
// A check holds busy through its walk and its drain: one step at the skipped endpoint, one grid
// read per cell on the single read port, one drain. done follows in the next cycle,
// in which the next transfer may already be taken.
// Equal endpoints skip the walk: busy for one cycle, done in the cycle after.
// Reset clears control only; the grid holds nothing valid until cells are written.
// done is a one-cycle strobe; the receiver cannot stall it.
module grid_line_of_sight_check #(
    parameter int GRID_X_BITS = 9,
    parameter int GRID_Y_BITS = 9
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  glos_pkg::cmd_t    cmd,
    output logic              done,
    output glos_pkg::result_t result
);

    import glos_pkg::*;

    `include "assert_macros.svh"

    localparam int ADDR_W = GRID_X_BITS + GRID_Y_BITS;
    localparam int DEPTH  = 1 << ADDR_W;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_WALK  = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic               rd_valid_reg;
    logic               clear_reg;
    logic               done_reg;
    logic [COORD_W-1:0] count_reg;
    result_t            result_reg;

    logic               accept;
    logic               wr_en;
    logic               load;
    logic [ADDR_W-1:0]  waddr;
    logic [ADDR_W-1:0]  raddr;
    logic               ram_re;
    logic               ram_rdata;
    logic               advance;
    logic               hit;
    logic               final_clear;

    logic [COORD_W-1:0] dx, dy;
    logic               a_first;
    step_cfg_t          setup;
    logic [COORD_W-1:0] end_minor;
    logic [COORD_W-1:0] cell_x, cell_y;
    step_stat_t         stat;

    assign accept = start && !busy;
    assign wr_en  = accept && (cmd.operation == OP_WRITE);
    assign load   = accept && (cmd.operation == OP_CHECK);
    assign waddr  = {GRID_X_BITS'(cmd.point_a_x), GRID_Y_BITS'(cmd.point_a_y)};
    assign raddr  = {GRID_X_BITS'(cell_x), GRID_Y_BITS'(cell_y)};

    // Walk setup: start from the endpoint lower on the major axis
    always_comb
    begin
        dx = (cmd.point_a_x > cmd.point_b_x) ? cmd.point_a_x - cmd.point_b_x
                                             : cmd.point_b_x - cmd.point_a_x;
        dy = (cmd.point_a_y > cmd.point_b_y) ? cmd.point_a_y - cmd.point_b_y
                                             : cmd.point_b_y - cmd.point_a_y;
        setup.y_major = (dx < dy);
        if (!setup.y_major)
        begin
            a_first           = (cmd.point_a_x < cmd.point_b_x);
            setup.major_start = a_first ? cmd.point_a_x : cmd.point_b_x;
            setup.minor_start = a_first ? cmd.point_a_y : cmd.point_b_y;
            end_minor         = a_first ? cmd.point_b_y : cmd.point_a_y;
            setup.major_delta = dx;
        end
        else
        begin
            a_first           = (cmd.point_a_y < cmd.point_b_y);
            setup.major_start = a_first ? cmd.point_a_y : cmd.point_b_y;
            setup.minor_start = a_first ? cmd.point_a_x : cmd.point_b_x;
            end_minor         = a_first ? cmd.point_b_x : cmd.point_a_x;
            setup.major_delta = dy;
        end
        setup.minor_delta = $signed({1'b0, end_minor}) - $signed({1'b0, setup.minor_start});
    end

    glos_stepper u_stepper (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (load),
        .cfg     (setup),
        .advance (advance),
        .cell_x  (cell_x),
        .cell_y  (cell_y),
        .stat    (stat)
    );

    glos_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (wr_en),
        .waddr (waddr),
        .wdata (cmd.cell_blocked),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    assign hit         = rd_valid_reg && ram_rdata;
    assign final_clear = clear_reg && !hit;

    always_comb
    begin
        state_next = state_reg;
        advance    = 1'b0;
        ram_re     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (load)
                begin
                    state_next = (setup.major_delta == '0) ? ST_DRAIN : ST_WALK;
                end
            end
            ST_WALK:
            begin
                // step 0 is the skipped endpoint: no read there
                ram_re  = !stat.at_start;
                advance = !stat.at_end;
                if (stat.at_end)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_valid_reg <= 1'b0;
            clear_reg    <= 1'b1;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= ram_re;
            done_reg     <= (state_reg == ST_DRAIN);
            if (load)
            begin
                clear_reg <= 1'b1;
            end
            else if (hit)
            begin
                clear_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            count_reg <= setup.major_delta;
        end
        if (state_reg == ST_DRAIN)
        begin
            result_reg.line_clear    <= final_clear;
            result_reg.cells_visited <= count_reg;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    `GLOS_ASSERT(a_done_idle, clk, rst_n, !done || !busy,
        "result strobe while a check is still walking")
    `GLOS_ASSERT_NEXT(a_drain_done, clk, rst_n, state_reg == ST_DRAIN, done,
        "drain cycle not followed by a result transfer")
    `GLOS_ASSERT(a_read_walk, clk, rst_n, !ram_re || (state_reg == ST_WALK && !wr_en),
        "grid read outside a walk or colliding with a write")
    `GLOS_ASSERT_NEXT(a_data_drain, clk, rst_n,
        state_reg == ST_WALK && stat.at_end,
        state_reg == ST_DRAIN && rd_valid_reg,
        "last cell read data missing at drain")

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench: grid writes and line-of-sight checks against a tracked grid copy.
module tb_top;
    import glos_pkg::*;

    localparam int GRID_SIDE     = 1 << COORD_W;
    localparam int COORD_MAX     = GRID_SIDE - 1;
    localparam int CELLS         = GRID_SIDE * GRID_SIDE;
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int SETTLE_CYCLES = 520;
    // short lines stay in a small corner window so few cells need a first write
    localparam int WIN_MAX       = 9;
    localparam int ITEM_TARGET   = 700;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    cmd_t    cmd = '0;
    logic    busy;
    logic    done;
    result_t result;

    // grid copy plus a map of cells that hold a defined value
    bit          occupied [CELLS];
    bit          known [CELLS];
    result_t     pending_sight [$];
    result_t     sight_due;
    int unsigned line_x [$];
    int unsigned line_y [$];
    int unsigned last_ax, last_ay, last_bx, last_by;
    int unsigned fill_pct;
    int unsigned sent_count;
    int          calm_left;
    int          cycle_count = 0;
    bit          failed = 1'b0;

    grid_line_of_sight_check dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d results outstanding",
                   cycle_count, pending_sight.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // results are one-cycle strobes; compare each against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_sight.size() == 0)
            begin
                $error("unexpected result: line_clear %0d cells_visited %0d",
                       result.line_clear, result.cells_visited);
                failed = 1'b1;
            end
            else
            begin
                sight_due = pending_sight.pop_front();
                if (result.line_clear !== sight_due.line_clear)
                begin
                    $error("line_clear: expected %0d, actual %0d",
                           sight_due.line_clear, result.line_clear);
                    failed = 1'b1;
                end
                if (result.cells_visited !== sight_due.cells_visited)
                begin
                    $error("cells_visited: expected %0d, actual %0d",
                           sight_due.cells_visited, result.cells_visited);
                    failed = 1'b1;
                end
            end
        end
    end

    function automatic int unsigned cell_at(int unsigned x, int unsigned y);
        return (x << COORD_W) | y;
    endfunction

    function automatic int floor_ratio(int num, int den);
        if (num >= 0)
            return num / den;
        return -((-num + den - 1) / den);
    endfunction

    function automatic void add_step(int x, int y);
        line_x = {line_x, $unsigned(x)};
        line_y = {line_y, $unsigned(y)};
    endfunction

    // Cells visited going from the endpoint with the lower major coordinate;
    // that endpoint is left out, the far one is included.
    function automatic void walk_line(int ax, int ay, int bx, int by);
        int dx, dy, s_maj, s_min, e_min;
        dx = ax > bx ? ax - bx : bx - ax;
        dy = ay > by ? ay - by : by - ay;
        line_x.delete();
        line_y.delete();
        if (dx >= dy)
        begin
            if (ax < bx)
            begin
                s_maj = ax; s_min = ay; e_min = by;
            end
            else
            begin
                s_maj = bx; s_min = by; e_min = ay;
            end
            for (int i = 1; i <= dx; i++)
            begin
                add_step(s_maj + i, s_min + floor_ratio(i * (e_min - s_min), dx));
            end
        end
        else
        begin
            if (ay < by)
            begin
                s_maj = ay; s_min = ax; e_min = bx;
            end
            else
            begin
                s_maj = by; s_min = bx; e_min = ax;
            end
            for (int i = 1; i <= dy; i++)
            begin
                add_step(s_min + floor_ratio(i * (e_min - s_min), dy), s_maj + i);
            end
        end
    endfunction

    // Applies one accepted command to the grid copy, queues the expected sight result.
    function automatic void predict_cmd(cmd_t c);
        result_t r;
        if (c.operation == OP_WRITE)
        begin
            occupied[cell_at(c.point_a_x, c.point_a_y)] = c.cell_blocked;
            known[cell_at(c.point_a_x, c.point_a_y)]    = 1'b1;
            return;
        end
        walk_line(c.point_a_x, c.point_a_y, c.point_b_x, c.point_b_y);
        r.line_clear = 1'b1;
        foreach (line_x[k])
            if (occupied[cell_at(line_x[k], line_y[k])])
                r.line_clear = 1'b0;
        r.cells_visited = COORD_W'(line_x.size());
        pending_sight = {pending_sight, r};
    endfunction

    function automatic cmd_t make_write(int unsigned x, int unsigned y, bit blocked);
        cmd_t c;
        c.operation    = OP_WRITE;
        c.point_a_x    = COORD_W'(x);
        c.point_a_y    = COORD_W'(y);
        c.point_b_x    = COORD_W'($urandom);
        c.point_b_y    = COORD_W'($urandom);
        c.cell_blocked = blocked;
        return c;
    endfunction

    function automatic cmd_t make_check(int unsigned ax, int unsigned ay,
                                        int unsigned bx, int unsigned by);
        cmd_t c;
        c.operation    = OP_CHECK;
        c.point_a_x    = COORD_W'(ax);
        c.point_a_y    = COORD_W'(ay);
        c.point_b_x    = COORD_W'(bx);
        c.point_b_y    = COORD_W'(by);
        c.cell_blocked = 1'($urandom_range(1));
        return c;
    endfunction

    // mostly back-to-back, some short gaps, a few long ones, and idle-free stretches
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        roll = $urandom_range(99);
        if (roll < 3)
        begin
            calm_left = $urandom_range(60, 20);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 5);
    endfunction

    // start stays high after a transfer when the next command follows at once
    task automatic send_cmd(cmd_t c, int unsigned gap);
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_cmd(c);
        sent_count++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_sight.size() != 0);
    endtask

    // every cell a check will read gets a defined value first
    task automatic fill_line(int unsigned ax, int unsigned ay,
                             int unsigned bx, int unsigned by);
        int unsigned xs [$];
        int unsigned ys [$];
        walk_line(ax, ay, bx, by);
        xs = line_x;
        ys = line_y;
        foreach (xs[k])
            if (!known[cell_at(xs[k], ys[k])])
                send_cmd(make_write(xs[k], ys[k], $urandom_range(99) < fill_pct), 0);
    endtask

    task automatic check_line(int unsigned ax, int unsigned ay,
                              int unsigned bx, int unsigned by, int unsigned gap);
        fill_line(ax, ay, bx, by);
        last_ax = ax;
        last_ay = ay;
        last_bx = bx;
        last_by = by;
        send_cmd(make_check(ax, ay, bx, by), gap);
    endtask

    // short lines inside the corner window, or long ones along row 0 (fully written)
    task automatic random_check();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70)
            check_line($urandom_range(WIN_MAX), $urandom_range(WIN_MAX),
                       $urandom_range(WIN_MAX), $urandom_range(WIN_MAX), pick_gap());
        else
            check_line($urandom_range(COORD_MAX), 0, $urandom_range(COORD_MAX), 0,
                       pick_gap());
    endtask

    // flip one cell on the previous line, then look along it again
    task automatic revisit_line();
        int unsigned k;
        walk_line(last_ax, last_ay, last_bx, last_by);
        if (line_x.size() == 0)
        begin
            random_check();
            return;
        end
        k = $urandom_range(line_x.size() - 1);
        send_cmd(make_write(line_x[k], line_y[k], 1'($urandom_range(1))), pick_gap());
        if ($urandom_range(1))
            check_line(last_bx, last_by, last_ax, last_ay, pick_gap());
        else
            check_line(last_ax, last_ay, last_bx, last_by, pick_gap());
    endtask

    task automatic test_equal_endpoints();
        fill_pct = 0;
        check_line(0, 0, 0, 0, 1);
        check_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0);
        send_cmd(make_write(200, 200, 1'b1), 0);
        check_line(200, 200, 200, 200, 0);
        drain_results();
    endtask

    task automatic test_straight_lines();
        fill_pct = 0;
        // full-length line: largest count
        check_line(0, 0, COORD_MAX, 0, 0);
        check_line(COORD_MAX, 0, 0, 0, 2);
        check_line(0, 0, 0, WIN_MAX, 0);
        check_line(0, WIN_MAX, 0, 0, 0);
        // dx == dy walks along x
        check_line(0, 0, WIN_MAX, WIN_MAX, 0);
        check_line(WIN_MAX, 0, 0, WIN_MAX, 3);
        check_line(0, 7, WIN_MAX, 2, 0);
        check_line(2, 0, 4, WIN_MAX, 0);
        drain_results();
    endtask

    task automatic test_blocked_cells();
        fill_pct = 0;
        check_line(100, 0, 110, 0, 1);
        // far endpoint is part of the walk
        send_cmd(make_write(110, 0, 1'b1), 0);
        check_line(100, 0, 110, 0, 0);
        send_cmd(make_write(110, 0, 1'b0), 0);
        // near endpoint is skipped, whichever of a and b it is
        send_cmd(make_write(100, 0, 1'b1), 0);
        check_line(100, 0, 110, 0, 2);
        check_line(110, 0, 100, 0, 0);
        // blocked on the first step still reports the full count
        send_cmd(make_write(101, 0, 1'b1), 0);
        check_line(110, 0, 100, 0, 0);
        send_cmd(make_write(100, 0, 1'b0), 0);
        send_cmd(make_write(101, 0, 1'b0), 0);
        // y-major line, walked from the lower y
        check_line(3, 9, 5, 1, 0);
        send_cmd(make_write(5, 1, 1'b1), 0);
        check_line(3, 9, 5, 1, 0);
        send_cmd(make_write(3, 9, 1'b1), 0);
        check_line(5, 1, 3, 9, 0);
        drain_results();
    endtask

    // write then read the same cell with no idle cycle between transfers
    task automatic test_back_to_back();
        int unsigned x, y;
        fill_pct = 0;
        fill_line(1, 1, 7, 4);
        walk_line(1, 1, 7, 4);
        x = line_x[0];
        y = line_y[0];
        send_cmd(make_write(x, y, 1'b1), 0);
        check_line(1, 1, 7, 4, 0);
        send_cmd(make_write(x, y, 1'b0), 0);
        check_line(7, 4, 1, 1, 0);
        check_line(4, 1, 1, 7, 0);
        drain_results();
    endtask

    task automatic test_random_traffic(int unsigned target);
        int unsigned roll;
        for (int i = 0; i < 100 || sent_count < target; i++)
        begin
            if (i % 25 == 0)
                case ($urandom_range(3))
                    0: fill_pct = 0;
                    1: fill_pct = 5;
                    2: fill_pct = 20;
                    default: fill_pct = 40;
                endcase
            // sender holds off until the block has answered everything
            if (i % 40 == 20)
                drain_results();
            roll = $urandom_range(99);
            if (roll < 60)
                random_check();
            else if (roll < 80)
                revisit_line();
            else if (roll < 95)
                send_cmd(make_write($urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                                    1'($urandom_range(1))), pick_gap());
            else
            begin
                roll = $urandom_range(COORD_MAX);
                check_line(roll, last_by, roll, last_by, pick_gap());
            end
        end
    endtask

    initial
    begin
        calm_left  = 0;
        fill_pct   = 0;
        sent_count = 0;
        last_ax    = 0;
        last_ay    = 0;
        last_bx    = 0;
        last_by    = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_equal_endpoints();
        test_straight_lines();
        test_blocked_cells();
        test_back_to_back();
        test_random_traffic(ITEM_TARGET);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failed)
            $display("*** FAILED ***");
        else
            $display("*** PASSED ***");
        $finish;
    end

endmodule
